/* design/periodic_trilinear_grid_interp_defines.svh */
// Assertion helpers shared by the grid interpolator RTL.
`ifndef PERIODIC_TRILINEAR_GRID_INTERP_DEFINES_SVH
`define PERIODIC_TRILINEAR_GRID_INTERP_DEFINES_SVH

// Plain property checked on every clock edge out of reset.
`define PTI_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Same-cycle implication.
`define PTI_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* design/pti_pkg.sv */
package pti_pkg;

  // request opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // config register indexes
  localparam logic [2:0] REG_GRID_EN   = 3'd0;
  localparam logic [2:0] REG_SIZE_X    = 3'd1;
  localparam logic [2:0] REG_SIZE_Y    = 3'd2;
  localparam logic [2:0] REG_SIZE_Z    = 3'd3;
  localparam logic [2:0] REG_ORIGIN_X  = 3'd4;
  localparam logic [2:0] REG_ORIGIN_Y  = 3'd5;
  localparam logic [2:0] REG_ORIGIN_Z  = 3'd6;
  localparam logic [2:0] REG_INV_STEP  = 3'd7;

  localparam int unsigned MAX_DIM    = 32;
  localparam int unsigned SIZE_W     = 6;
  localparam int unsigned DIM_W      = 5;
  localparam int unsigned VAL_W      = 32;
  localparam int unsigned FR_W       = 16;
  localparam int unsigned CIDX_W     = 15;
  localparam int unsigned MOD_BITS   = 7;
  localparam int unsigned MOD_STAGES = 5;
  localparam int unsigned Q_W        = MOD_BITS * MOD_STAGES;
  localparam logic [FR_W:0] W_ONE    = 17'h10000;

  typedef struct packed {
    logic                     op;
    logic                     err;
    logic [CIDX_W-1:0]        cidx;
    logic [VAL_W-1:0]         cval;
    logic [2:0][FR_W-1:0]     fr;
  } item_t;

  typedef struct packed {
    logic             neg;
    logic [Q_W-1:0]   q;
    logic [DIM_W-1:0] r;
  } ax_t;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] s);
    logic [SIZE_W-1:0] n;
    n = s;
    if (s == '0) n = SIZE_W'(1);
    else if (s > SIZE_W'(MAX_DIM)) n = SIZE_W'(MAX_DIM);
    return n;
  endfunction

  // restoring remainder, MOD_BITS quotient bits per call
  function automatic logic [DIM_W-1:0] mod_step(input logic [DIM_W-1:0] r,
                                                input logic [MOD_BITS-1:0] bits,
                                                input logic [SIZE_W-1:0] n);
    logic [SIZE_W-1:0] t;
    logic [DIM_W-1:0]  acc;
    acc = r;
    for (int i = MOD_BITS - 1; i >= 0; i--) begin
      t = {acc, bits[i]};
      if (t >= n) t = t - n;
      acc = t[DIM_W-1:0];
    end
    return acc;
  endfunction

endpackage

/* design/pti_ram.sv */
module pti_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/periodic_trilinear_grid_interp.sv */
// Periodic trilinear density grid. Write requests (op 0) store one 32-bit cell
// at a linear index i*Ny*Nz+j*Nz+k and are answered with density 0, status 0.
// Query requests (op 1) map a Q16.16 position into grid space, wrap the floor
// cell and its upper neighbor on each axis modulo the grid size (negative
// positions included) and return the truncated trilinear blend of the eight
// corners. A query while grid_enabled is 0 returns status 1, density 0.
// Throughput is one request per clock while out_ready_i accepts responses;
// each request passes through the 15-stage pipeline (subtract, 32x32 multiply,
// floor, five 7-bit stages of the periodic remainder, index, offsets,
// address, memory read, three blend multiply stages). The store is held as
// eight identical copies so all corners read in the same cycle; every write
// goes to all copies. Writes commit at the memory stage, so request order is
// kept between writes and queries. The store has no reset; read only written
// cells. Write configuration only while the pipeline is empty.
`include "periodic_trilinear_grid_interp_defines.svh"

module periodic_trilinear_grid_interp #(
  parameter int unsigned GRID_CELLS = 32768
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // config
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_idx_i,
  input  logic [31:0]          cfg_wdata_i,
  // request
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 op_i,
  input  logic [14:0]          cell_index_i,
  input  logic [31:0]          cell_value_i,
  input  logic signed [31:0]   pos_x_i,
  input  logic signed [31:0]   pos_y_i,
  input  logic signed [31:0]   pos_z_i,
  // response
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [31:0]          density_o,
  output logic                 status_o
);

  localparam int unsigned AW = (GRID_CELLS > 1) ? $clog2(GRID_CELLS) : 1;

  // stage numbers
  localparam int unsigned S_DIFF = 0;
  localparam int unsigned S_MUL  = 1;
  localparam int unsigned S_Q    = 2;
  localparam int unsigned S_IDX  = S_Q + pti_pkg::MOD_STAGES + 1;
  localparam int unsigned S_OFF  = S_IDX + 1;
  localparam int unsigned S_ADDR = S_OFF + 1;
  localparam int unsigned S_MEM  = S_ADDR + 1;
  localparam int unsigned S_LZ   = S_MEM + 1;
  localparam int unsigned S_LY   = S_LZ + 1;
  localparam int unsigned S_OUT  = S_LY + 1;
  localparam int unsigned NSTG   = S_OUT + 1;

  localparam int unsigned SW = pti_pkg::SIZE_W;
  localparam int unsigned DW = pti_pkg::DIM_W;
  localparam int unsigned FW = pti_pkg::FR_W;

  // ---------------------------------------------------------------- config
  logic        grid_en_q;
  logic [SW-1:0] size_q [3];
  logic [31:0] org_q [3];
  logic [31:0] inv_step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_en_q  <= 1'b0;
      size_q[0]  <= SW'(1);
      size_q[1]  <= SW'(1);
      size_q[2]  <= SW'(1);
      org_q[0]   <= '0;
      org_q[1]   <= '0;
      org_q[2]   <= '0;
      inv_step_q <= 32'h0001_0000;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pti_pkg::REG_GRID_EN:  grid_en_q  <= cfg_wdata_i[0];
        pti_pkg::REG_SIZE_X:   size_q[0]  <= cfg_wdata_i[SW-1:0];
        pti_pkg::REG_SIZE_Y:   size_q[1]  <= cfg_wdata_i[SW-1:0];
        pti_pkg::REG_SIZE_Z:   size_q[2]  <= cfg_wdata_i[SW-1:0];
        pti_pkg::REG_ORIGIN_X: org_q[0]   <= cfg_wdata_i;
        pti_pkg::REG_ORIGIN_Y: org_q[1]   <= cfg_wdata_i;
        pti_pkg::REG_ORIGIN_Z: org_q[2]   <= cfg_wdata_i;
        pti_pkg::REG_INV_STEP: inv_step_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // effective sizes, 1..MAX_DIM
  logic [SW-1:0] nsz [3];
  logic [10:0]   nyz;
  always_comb begin
    for (int a = 0; a < 3; a++) nsz[a] = pti_pkg::clamp_size(size_q[a]);
    nyz = 11'(nsz[1]) * 11'(nsz[2]);
  end

  // ------------------------------------------------------- pipeline control
  // Each stage moves when it is empty or its successor moves, so bubbles
  // collapse and a waiting response blocks new requests only once every
  // stage is full.
  logic [NSTG-1:0] vld_q;
  logic [NSTG-1:0] adv;

  always_comb begin
    adv[NSTG-1] = !vld_q[NSTG-1] || out_ready_i;
    for (int k = NSTG - 2; k >= 0; k--) adv[k] = !vld_q[k] || adv[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) vld_q[0] <= in_valid_i;
      for (int k = 1; k < NSTG; k++) begin
        if (adv[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = vld_q[NSTG-1];

  // request descriptor that rides along every stage
  pti_pkg::item_t itm_q [NSTG];
  pti_pkg::item_t itm_in;
  pti_pkg::item_t itm_fr;

  always_comb begin
    itm_in.op   = op_i;
    itm_in.err  = (op_i == pti_pkg::OP_QUERY) && !grid_en_q;
    itm_in.cidx = cell_index_i;
    itm_in.cval = cell_value_i;
    itm_in.fr   = '0;
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) itm_q[0] <= itm_in;
    for (int k = 1; k < NSTG; k++) begin
      if (adv[k]) itm_q[k] <= (k == S_Q) ? itm_fr : itm_q[k-1];
    end
  end

  // ----------------------------------------------- stage: origin subtract
  logic signed [31:0] pos_in [3];
  logic signed [32:0] diff [3];
  logic [31:0]        mag_q [3];
  logic               neg1_q [3];

  always_comb begin
    pos_in[0] = pos_x_i;
    pos_in[1] = pos_y_i;
    pos_in[2] = pos_z_i;
    for (int a = 0; a < 3; a++) begin
      diff[a] = 33'(pos_in[a]) - 33'(signed'(org_q[a]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[S_DIFF]) begin
      for (int a = 0; a < 3; a++) begin
        neg1_q[a] <= diff[a][32];
        mag_q[a]  <= diff[a][32] ? 32'(-diff[a]) : diff[a][31:0];
      end
    end
  end

  // ------------------------------------------------ stage: scale by 1/step
  logic [63:0] m_q [3];
  logic        neg2_q [3];

  always_ff @(posedge clk_i) begin
    if (adv[S_MUL]) begin
      for (int a = 0; a < 3; a++) begin
        m_q[a]    <= 64'(mag_q[a]) * 64'(inv_step_q);
        neg2_q[a] <= neg1_q[a];
      end
    end
  end

  // ------------------------------------------- stage: floor and fraction
  // Negative side: floor index is -ceil(|x|), fraction from the two's
  // complement of the product.
  pti_pkg::ax_t ax_q [pti_pkg::MOD_STAGES+1][3];
  pti_pkg::ax_t ax_fl [3];
  logic [63:0]  mneg [3];
  logic [32:0]  qv [3];

  always_comb begin
    itm_fr = itm_q[S_Q-1];
    for (int a = 0; a < 3; a++) begin
      mneg[a] = 64'd0 - m_q[a];
      if (neg2_q[a]) begin
        qv[a] = 33'(m_q[a][63:32]) + 33'(|m_q[a][31:0]);
        itm_fr.fr[a] = mneg[a][31:16];
      end else begin
        qv[a] = 33'(m_q[a][63:32]);
        itm_fr.fr[a] = m_q[a][31:16];
      end
      ax_fl[a].neg = neg2_q[a];
      ax_fl[a].q   = pti_pkg::Q_W'(qv[a]);
      ax_fl[a].r   = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[S_Q]) begin
      for (int a = 0; a < 3; a++) ax_q[0][a] <= ax_fl[a];
    end
  end

  // ------------------------------------- stages: periodic remainder q % n
  for (genvar s = 1; s <= pti_pkg::MOD_STAGES; s++) begin : g_mod
    always_ff @(posedge clk_i) begin
      if (adv[S_Q + s]) begin
        for (int a = 0; a < 3; a++) begin
          ax_q[s][a].neg <= ax_q[s-1][a].neg;
          ax_q[s][a].q   <= ax_q[s-1][a].q << pti_pkg::MOD_BITS;
          ax_q[s][a].r   <= pti_pkg::mod_step(
              ax_q[s-1][a].r,
              ax_q[s-1][a].q[pti_pkg::Q_W-1 -: pti_pkg::MOD_BITS],
              nsz[a]);
        end
      end
    end
  end

  // ------------------------------------------------- stage: cell indexes
  logic [DW-1:0] idx0_q [3];
  logic [DW-1:0] idx1_q [3];
  logic [DW-1:0] idx0 [3];
  logic [DW-1:0] idx1 [3];
  logic [SW-1:0] rr [3];
  logic [SW-1:0] inc [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      rr[a] = SW'(ax_q[pti_pkg::MOD_STAGES][a].r);
      if (ax_q[pti_pkg::MOD_STAGES][a].neg && rr[a] != '0) begin
        idx0[a] = DW'(nsz[a] - rr[a]);
      end else begin
        idx0[a] = rr[a][DW-1:0];
      end
      inc[a]  = SW'(idx0[a]) + SW'(1);
      idx1[a] = (inc[a] == nsz[a]) ? '0 : inc[a][DW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[S_IDX]) begin
      for (int a = 0; a < 3; a++) begin
        idx0_q[a] <= idx0[a];
        idx1_q[a] <= idx1[a];
      end
    end
  end

  // ----------------------------------------------- stage: row offsets
  logic [15:0]   xoff_q [2];
  logic [9:0]    yoff_q [2];
  logic [DW-1:0] zc_q [2];

  always_ff @(posedge clk_i) begin
    if (adv[S_OFF]) begin
      xoff_q[0] <= 16'(idx0_q[0]) * 16'(nyz);
      xoff_q[1] <= 16'(idx1_q[0]) * 16'(nyz);
      yoff_q[0] <= 10'(idx0_q[1]) * 10'(nsz[2]);
      yoff_q[1] <= 10'(idx1_q[1]) * 10'(nsz[2]);
      zc_q[0]   <= idx0_q[2];
      zc_q[1]   <= idx1_q[2];
    end
  end

  // -------------------------------------------- stage: corner addresses
  // corner c = {dx, dy, dz}
  logic [16:0] caddr [8];
  logic [16:0] caddr_q [8];
  logic        oob_q [8];

  always_comb begin
    for (int c = 0; c < 8; c++) begin
      caddr[c] = 17'(xoff_q[c[2]]) + 17'(yoff_q[c[1]]) + 17'(zc_q[c[0]]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[S_ADDR]) begin
      for (int c = 0; c < 8; c++) begin
        caddr_q[c] <= caddr[c];
        oob_q[c]   <= 32'(caddr[c]) >= 32'(GRID_CELLS);
      end
    end
  end

  // ------------------------------------------------ stage: memory access
  logic            ram_we;
  logic            ram_re;
  logic [31:0]     ram_rd [8];
  logic            oob_m_q [8];
  logic [31:0]     cval_m [8];

  assign ram_we = adv[S_MEM] && vld_q[S_ADDR] &&
                  (itm_q[S_ADDR].op == pti_pkg::OP_WRITE) &&
                  (32'(itm_q[S_ADDR].cidx) < 32'(GRID_CELLS));
  assign ram_re = adv[S_MEM] && vld_q[S_ADDR] &&
                  (itm_q[S_ADDR].op == pti_pkg::OP_QUERY);

  for (genvar c = 0; c < 8; c++) begin : g_ram
    pti_ram #(
      .WIDTH (pti_pkg::VAL_W),
      .DEPTH (GRID_CELLS)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (ram_we),
      .waddr_i (AW'(itm_q[S_ADDR].cidx)),
      .wdata_i (itm_q[S_ADDR].cval),
      .re_i    (ram_re),
      .raddr_i (AW'(caddr_q[c])),
      .rdata_o (ram_rd[c])
    );
  end

  always_ff @(posedge clk_i) begin
    if (adv[S_MEM]) begin
      for (int c = 0; c < 8; c++) oob_m_q[c] <= oob_q[c];
    end
  end

  always_comb begin
    for (int c = 0; c < 8; c++) cval_m[c] = oob_m_q[c] ? '0 : ram_rd[c];
  end

  // ---------------------------------------------------- stage: blend z
  logic [FW:0]  wz_lo, wz_hi;
  logic [47:0]  lz_q [4];

  assign wz_hi = (FW+1)'(itm_q[S_MEM].fr[2]);
  assign wz_lo = pti_pkg::W_ONE - wz_hi;

  always_ff @(posedge clk_i) begin
    if (adv[S_LZ]) begin
      for (int l = 0; l < 4; l++) begin
        lz_q[l] <= 48'(cval_m[2*l]) * 48'(wz_lo) + 48'(cval_m[2*l+1]) * 48'(wz_hi);
      end
    end
  end

  // ---------------------------------------------------- stage: blend y
  logic [FW:0]  wy_lo, wy_hi;
  logic [63:0]  s_q [2];

  assign wy_hi = (FW+1)'(itm_q[S_LZ].fr[1]);
  assign wy_lo = pti_pkg::W_ONE - wy_hi;

  always_ff @(posedge clk_i) begin
    if (adv[S_LY]) begin
      for (int d = 0; d < 2; d++) begin
        s_q[d] <= 64'(lz_q[2*d]) * 64'(wy_lo) + 64'(lz_q[2*d+1]) * 64'(wy_hi);
      end
    end
  end

  // ------------------------------------------- stage: blend x, response
  logic [FW:0]  wx_lo, wx_hi;
  logic [79:0]  tot;
  logic [31:0]  dens_q;
  logic         stat_q;

  assign wx_hi = (FW+1)'(itm_q[S_LY].fr[0]);
  assign wx_lo = pti_pkg::W_ONE - wx_hi;
  assign tot   = 80'(s_q[0]) * 80'(wx_lo) + 80'(s_q[1]) * 80'(wx_hi);

  always_ff @(posedge clk_i) begin
    if (adv[S_OUT]) begin
      stat_q <= itm_q[S_LY].err;
      dens_q <= (itm_q[S_LY].op == pti_pkg::OP_QUERY && !itm_q[S_LY].err) ?
                tot[79:48] : '0;
    end
  end

  assign density_o = dens_q;
  assign status_o  = stat_q;

  // ------------------------------------------------------------ checks
  `PTI_ASSERT_IMPL(a_empty_ready, !out_valid_o, in_ready_o,
                   "pipeline drained but request side not ready")
  `PTI_ASSERT_IMPL(a_err_zero, out_valid_o && status_o, density_o == '0,
                   "error response carries nonzero density")
  `PTI_ASSERT_IMPL(a_write_resp, out_valid_o && itm_q[S_OUT].op == pti_pkg::OP_WRITE,
                   !status_o && density_o == '0, "write response not clean")
  `PTI_ASSERT_IMPL(a_idx_range,
                   vld_q[S_IDX] && itm_q[S_IDX].op == pti_pkg::OP_QUERY,
                   SW'(idx0_q[0]) < nsz[0] && SW'(idx1_q[1]) < nsz[1] &&
                   SW'(idx0_q[2]) < nsz[2], "wrapped index out of grid")

endmodule
